[rtl/ufmt_pkg.sv]
// ----------------------------------------------------------------------------
// ufmt_pkg: shared types and constants of the unsigned decimal formatter
// Holds the input and result word layouts and the fixed widths and
// characters used by the conversion datapath.
// ----------------------------------------------------------------------------
package ufmt_pkg;

    localparam int VALUE_W    = 64;   // width of the binary value
    localparam int STEP_W     = 6;    // counts the bits of the value
    localparam int DIGITS     = 20;   // decimal digits of the largest value
    localparam int DIG_W      = 5;    // holds a digit count up to DIGITS
    localparam int BCD_W      = 4 * DIGITS;
    localparam int SPEC_W     = 7;    // width and precision fields

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               width_on;
        logic [SPEC_W-1:0]  field_width;
        logic               prec_on;
        logic [SPEC_W-1:0]  min_digits;
        logic               left_align;
        logic               zero_pad;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } out_word_t;

endpackage

[rtl/unsigned_decimal_field_formatter_unit.sv]
// ----------------------------------------------------------------------------
// unsigned_decimal_field_formatter_unit: printf-style %u field formatter
// Turns one 64-bit unsigned value and its format spec into the ASCII
// characters of the formatted field, one character per output word.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid, s_ready, s_data) takes one word holding the
//   value, the width and precision with their enables, and the left-align
//   and zero-pad flags. The output channel (m_valid, m_ready, m_data) then
//   delivers the field one character per word, with last set on the final
//   character. A field has between 1 and MAX_FIELD characters.
//   Operation: after a word is accepted, a bit-serial binary-to-BCD converter
//   takes one value bit per cycle, a leading-zero trim removes one digit
//   per cycle, a planning state works out the padding, and then one
//   character leaves per cycle while the receiver keeps m_ready high. One
//   word is in work at a time; s_ready is high whenever the block is idle,
//   also while the last character still waits in the output register.
//   If the receiver holds m_ready low, the output register keeps its word
//   and emission pauses without loss. Reset (aresetn low at a clock edge)
//   drops any field in progress and empties the output register.
// ----------------------------------------------------------------------------
module unsigned_decimal_field_formatter_unit #(
    parameter int MAX_FIELD = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ufmt_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ufmt_pkg::out_word_t  m_data
);

    localparam int CW    = $clog2(MAX_FIELD + 1);
    localparam int VW    = ufmt_pkg::VALUE_W;
    localparam int SW    = ufmt_pkg::STEP_W;
    localparam int NDW   = ufmt_pkg::DIG_W;
    localparam int BW    = ufmt_pkg::BCD_W;
    localparam int NDIG  = ufmt_pkg::DIGITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_TRIM = 3'd2;
    localparam logic [2:0] S_PLAN = 3'd3;
    localparam logic [2:0] S_LPAD = 3'd4;
    localparam logic [2:0] S_ZERO = 3'd5;
    localparam logic [2:0] S_DIG  = 3'd6;
    localparam logic [2:0] S_RPAD = 3'd7;

    logic [2:0]      state_reg, state_next;
    logic [VW-1:0]   bin_reg, bin_next;
    logic [BW-1:0]   bcd_reg, bcd_next;
    logic [SW-1:0]   step_reg, step_next;
    logic [NDW-1:0]  nd_reg, nd_next;
    logic [CW-1:0]   lpad_reg, lpad_next;
    logic [CW-1:0]   zero_reg, zero_next;
    logic [CW-1:0]   rpad_reg, rpad_next;
    logic            w_on_reg, w_on_next;
    logic [CW-1:0]   w_reg, w_next;
    logic            p_on_reg, p_on_next;
    logic [CW-1:0]   p_reg, p_next;
    logic            left_reg, left_next;
    logic            zpad_reg, zpad_next;
    logic            m_valid_reg, m_valid_next;
    ufmt_pkg::out_word_t m_data_reg, m_data_next;

    logic [BW-1:0]   bcd_adj;
    logic [CW-1:0]   nd_ext;
    logic [CW-1:0]   body;
    logic [CW-1:0]   pad;
    logic            out_load;
    logic [3:0]      top_digit;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_load  = !m_valid_reg || m_ready;
    assign top_digit = bcd_reg[BW-1 -: 4];

    // Double-dabble correction: every BCD digit of 5 or more gets 3 added
    // before the shift, so the shift carries it correctly into the next digit.
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    // The digit body is the longer of the significant digits and the
    // precision; width padding fills whatever remains.
    assign nd_ext = CW'(nd_reg);
    assign body   = (p_on_reg && (p_reg > nd_ext)) ? p_reg : nd_ext;
    assign pad    = (w_on_reg && (w_reg > body)) ? (w_reg - body) : '0;

    always_comb begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        step_next    = step_reg;
        nd_next      = nd_reg;
        lpad_next    = lpad_reg;
        zero_next    = zero_reg;
        rpad_next    = rpad_reg;
        w_on_next    = w_on_reg;
        w_next       = w_reg;
        p_on_next    = p_on_reg;
        p_next       = p_reg;
        left_next    = left_reg;
        zpad_next    = zpad_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    bin_next  = s_data.value;
                    bcd_next  = '0;
                    step_next = '0;
                    w_on_next = s_data.width_on;
                    p_on_next = s_data.prec_on;
                    left_next = s_data.left_align;
                    zpad_next = s_data.zero_pad;
                    if (32'(s_data.field_width) > MAX_FIELD) begin
                        w_next = CW'(MAX_FIELD);
                    end else begin
                        w_next = CW'(s_data.field_width);
                    end
                    if (32'(s_data.min_digits) > MAX_FIELD) begin
                        p_next = CW'(MAX_FIELD);
                    end else begin
                        p_next = CW'(s_data.min_digits);
                    end
                    state_next = S_CONV;
                end
            end
            S_CONV: begin
                bcd_next  = {bcd_adj[BW-2:0], bin_reg[VW-1]};
                bin_next  = {bin_reg[VW-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(VW - 1)) begin
                    nd_next    = NDW'(NDIG);
                    state_next = S_TRIM;
                end
            end
            S_TRIM: begin
                // Drop leading zero digits, but always keep one digit.
                if ((nd_reg > NDW'(1)) && (top_digit == 4'd0)) begin
                    bcd_next = {bcd_reg[BW-5:0], 4'd0};
                    nd_next  = nd_reg - 1'b1;
                end else begin
                    state_next = S_PLAN;
                end
            end
            S_PLAN: begin
                if ((pad != '0) && !p_on_reg && zpad_reg) begin
                    lpad_next = '0;
                    zero_next = pad;
                    rpad_next = '0;
                end else begin
                    lpad_next = left_reg ? '0 : pad;
                    zero_next = body - nd_ext;
                    rpad_next = left_reg ? pad : '0;
                end
                if (!left_reg && (pad != '0) && (p_on_reg || !zpad_reg)) begin
                    state_next = S_LPAD;
                end else if ((body != nd_ext) ||
                             ((pad != '0) && !p_on_reg && zpad_reg)) begin
                    state_next = S_ZERO;
                end else begin
                    state_next = S_DIG;
                end
            end
            S_LPAD: begin
                if (out_load) begin
                    m_valid_next         = 1'b1;
                    m_data_next.out_char = ufmt_pkg::CHAR_SPACE;
                    m_data_next.last     = 1'b0;
                    lpad_next            = lpad_reg - 1'b1;
                    if (lpad_reg == CW'(1)) begin
                        state_next = (zero_reg != '0) ? S_ZERO : S_DIG;
                    end
                end
            end
            S_ZERO: begin
                if (out_load) begin
                    m_valid_next         = 1'b1;
                    m_data_next.out_char = ufmt_pkg::CHAR_ZERO;
                    m_data_next.last     = 1'b0;
                    zero_next            = zero_reg - 1'b1;
                    if (zero_reg == CW'(1)) begin
                        state_next = S_DIG;
                    end
                end
            end
            S_DIG: begin
                if (out_load) begin
                    m_valid_next         = 1'b1;
                    m_data_next.out_char = ufmt_pkg::CHAR_ZERO | {4'd0, top_digit};
                    m_data_next.last     = (nd_reg == NDW'(1)) && (rpad_reg == '0);
                    bcd_next             = {bcd_reg[BW-5:0], 4'd0};
                    nd_next              = nd_reg - 1'b1;
                    if (nd_reg == NDW'(1)) begin
                        state_next = (rpad_reg != '0) ? S_RPAD : S_IDLE;
                    end
                end
            end
            S_RPAD: begin
                if (out_load) begin
                    m_valid_next         = 1'b1;
                    m_data_next.out_char = ufmt_pkg::CHAR_SPACE;
                    m_data_next.last     = (rpad_reg == CW'(1));
                    rpad_next            = rpad_reg - 1'b1;
                    if (rpad_reg == CW'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        step_reg   <= step_next;
        nd_reg     <= nd_next;
        lpad_reg   <= lpad_next;
        zero_reg   <= zero_next;
        rpad_reg   <= rpad_next;
        w_on_reg   <= w_on_next;
        w_reg      <= w_next;
        p_on_reg   <= p_on_next;
        p_reg      <= p_next;
        left_reg   <= left_next;
        zpad_reg   <= zpad_next;
        m_data_reg <= m_data_next;
    end

    // An accepted word starts the converter right away.
    a_accept_starts_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_CONV))
        else $error("accepted word did not start conversion");

    // The digit phases always have at least one digit left to send.
    a_digits_present: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DIG) || (state_reg == S_TRIM)) |-> (nd_reg != '0))
        else $error("digit phase entered with no digits");

    // Every emitted character is a space or a decimal digit.
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg.out_char == ufmt_pkg::CHAR_SPACE) ||
                         ((m_data_reg.out_char >= ufmt_pkg::CHAR_ZERO) &&
                          (m_data_reg.out_char <= 8'h39))))
        else $error("output character outside the field alphabet");

    // Loading the last character of a field returns the block to idle.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && m_valid_next && m_data_next.last) |=> (state_reg == S_IDLE))
        else $error("field continues after its last character");

    // Emission phases only advance when the output register can take a word.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_data_reg))
        else $error("pending output word was overwritten");

endmodule
